// ===== rtl/core/rti_pkg.sv =====
// Shared types and widths for the ray/triangle intersection tester.
// No dependencies; every other file imports this package.
`default_nettype none
package rti_pkg;
  localparam int unsigned CoordWidth = 32;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned DistWidth = 31;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned NumRegs = 6;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5
  } rti_reg_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] a_x;
    logic signed [CoordWidth-1:0] a_y;
    logic signed [CoordWidth-1:0] a_z;
    logic signed [CoordWidth-1:0] b_x;
    logic signed [CoordWidth-1:0] b_y;
    logic signed [CoordWidth-1:0] b_z;
    logic signed [CoordWidth-1:0] c_x;
    logic signed [CoordWidth-1:0] c_y;
    logic signed [CoordWidth-1:0] c_z;
  } rti_tri_t;

  typedef struct packed {
    logic                 hit;
    logic [DistWidth-1:0] distance;
  } rti_res_t;

  // valid and hit flag travelling alongside a pipeline stage
  typedef struct packed {
    logic valid;
    logic hit;
  } rti_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/core/rti_cross.sv =====
// Edge vectors and the two cross products P = dir x E2, Q = T x E1.
// Three register stages; depends on rti_pkg.
`default_nettype none
module rti_cross import rti_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  rti_tri_t                     tri_i,
  input  logic signed [CoordWidth-1:0] org_i [3],
  input  logic signed [CoordWidth-1:0] dir_i [3],
  output logic                         valid_o,
  output logic signed [2*CoordWidth+2:0] p_o [3],
  output logic signed [2*CoordWidth+2:0] q_o [3],
  output logic signed [CoordWidth:0]   e1_o [3],
  output logic signed [CoordWidth:0]   e2_o [3],
  output logic signed [CoordWidth:0]   tv_o [3]
);
  localparam int unsigned DW = CoordWidth + 1;
  localparam int unsigned MW = 2 * DW;

  logic signed [CoordWidth-1:0] a [3], b [3], c [3];
  logic signed [DW-1:0] e1_q [3], e2_q [3], tv_q [3];
  logic signed [DW-1:0] e1_d [3], e2_d [3], tv_d [3], dx [3];
  logic signed [DW-1:0] e1_r_q [3], e2_r_q [3], tv_r_q [3];
  logic signed [MW-1:0] m_d [12], m_q [12];
  logic signed [MW:0]   p_d [3], q_d [3];
  logic [2:0] v_q;

  assign a = '{tri_i.a_x, tri_i.a_y, tri_i.a_z};
  assign b = '{tri_i.b_x, tri_i.b_y, tri_i.b_z};
  assign c = '{tri_i.c_x, tri_i.c_y, tri_i.c_z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1_d[i] = DW'(b[i]) - DW'(a[i]);
      e2_d[i] = DW'(c[i]) - DW'(a[i]);
      tv_d[i] = DW'(org_i[i]) - DW'(a[i]);
      dx[i]   = DW'(dir_i[i]);
    end
    // P = dir x E2
    m_d[0]  = dx[1] * e2_q[2];  m_d[1]  = dx[2] * e2_q[1];
    m_d[2]  = dx[2] * e2_q[0];  m_d[3]  = dx[0] * e2_q[2];
    m_d[4]  = dx[0] * e2_q[1];  m_d[5]  = dx[1] * e2_q[0];
    // Q = T x E1
    m_d[6]  = tv_q[1] * e1_q[2]; m_d[7]  = tv_q[2] * e1_q[1];
    m_d[8]  = tv_q[2] * e1_q[0]; m_d[9]  = tv_q[0] * e1_q[2];
    m_d[10] = tv_q[0] * e1_q[1]; m_d[11] = tv_q[1] * e1_q[0];
    for (int i = 0; i < 3; i++) begin
      p_d[i] = (MW+1)'(m_q[2*i]) - (MW+1)'(m_q[2*i+1]);
      q_d[i] = (MW+1)'(m_q[6+2*i]) - (MW+1)'(m_q[7+2*i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e1_q <= e1_d; e2_q <= e2_d; tv_q <= tv_d;
      m_q <= m_d;
      e1_r_q <= e1_q; e2_r_q <= e2_q; tv_r_q <= tv_q;
      p_o <= p_d; q_o <= q_d;
      e1_o <= e1_r_q; e2_o <= e2_r_q; tv_o <= tv_r_q;
    end
  end

  assign valid_o = v_q[2];
endmodule
`default_nettype wire

// ===== rtl/core/rti_dot.sv =====
// Dot products, sign normalisation and the barycentric and distance tests.
// Three register stages; depends on rti_pkg.
`default_nettype none
module rti_dot import rti_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic signed [2*CoordWidth+2:0] p_i [3],
  input  logic signed [2*CoordWidth+2:0] q_i [3],
  input  logic signed [CoordWidth:0]     e1_i [3],
  input  logic signed [CoordWidth:0]     e2_i [3],
  input  logic signed [CoordWidth:0]     tv_i [3],
  input  logic signed [CoordWidth-1:0]   dir_i [3],
  output rti_ctl_t                       ctl_o,
  output logic [3*CoordWidth+4:0]        num_o,
  output logic [3*CoordWidth+4:0]        den_o
);
  localparam int unsigned DW = CoordWidth + 1;
  localparam int unsigned PW = 2 * DW + 1;
  localparam int unsigned MW = PW + DW;
  localparam int unsigned SW = MW + 2;
  // split each P or Q component into an unsigned low slice and a signed high slice
  localparam int unsigned LW = PW / 2;
  localparam int unsigned HW = PW - LW;

  logic signed [PW-1:0]    op_a [12];
  logic signed [DW-1:0]    op_b [12];
  logic signed [LW+DW:0]   ml_d [12], ml_q [12];
  logic signed [HW+DW-1:0] mh_d [12], mh_q [12];
  logic signed [SW-1:0] s_d [4], s_q [4];
  logic signed [SW-1:0] det, un, vn, tn;
  logic signed [SW:0]   uv;
  logic [1:0] v_q;
  logic hit_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      op_a[i]   = p_i[i]; op_b[i]   = e1_i[i];
      op_a[3+i] = p_i[i]; op_b[3+i] = tv_i[i];
      op_a[6+i] = q_i[i]; op_b[6+i] = DW'(dir_i[i]);
      op_a[9+i] = q_i[i]; op_b[9+i] = e2_i[i];
    end
    for (int j = 0; j < 12; j++) begin
      ml_d[j] = $signed({1'b0, op_a[j][LW-1:0]}) * op_b[j];
      mh_d[j] = $signed(op_a[j][PW-1:LW]) * op_b[j];
    end
    for (int k = 0; k < 4; k++) begin
      s_d[k] = SW'(ml_q[3*k]) + SW'(ml_q[3*k+1]) + SW'(ml_q[3*k+2])
               + (SW'(mh_q[3*k]) <<< LW) + (SW'(mh_q[3*k+1]) <<< LW)
               + (SW'(mh_q[3*k+2]) <<< LW);
    end
    // flip all signs on a negative determinant so the tests are sign tests
    if (s_q[0][SW-1]) begin
      det = -s_q[0]; un = -s_q[1]; vn = -s_q[2]; tn = -s_q[3];
    end else begin
      det = s_q[0]; un = s_q[1]; vn = s_q[2]; tn = s_q[3];
    end
    uv = (SW+1)'(un) + (SW+1)'(vn);
    hit_d = (s_q[0] != '0) && !un[SW-1] && !vn[SW-1] && !tn[SW-1]
            && (uv <= (SW+1)'(det));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      ctl_o <= '0;
    end else if (en_i) begin
      v_q   <= {v_q[0], valid_i};
      ctl_o <= '{valid: v_q[1], hit: hit_d};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ml_q  <= ml_d;
      mh_q  <= mh_d;
      s_q   <= s_d;
      num_o <= tn[SW-2:0];
      den_o <= det[SW-2:0];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/rti_div.sv =====
// Restoring divider, one quotient bit per stage, with saturation check.
// Gives floor(num * 2^FRAC_BITS / den); depends on rti_pkg.
`default_nettype none
module rti_div import rti_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef,
  parameter int unsigned NW = 3 * CoordWidth + 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  rti_ctl_t      ctl_i,
  input  logic [NW-1:0] num_i,
  input  logic [NW-1:0] den_i,
  output logic          valid_o,
  output rti_res_t      res_o
);
  localparam int unsigned RW = NW + FRAC_BITS + DistWidth + 1;
  localparam int unsigned NS = DistWidth + 1;

  logic [RW-1:0] rem_q [NS], den_q [NS];
  logic [DistWidth-1:0] quo_q [NS];
  logic [NS-1:0] val_q, hit_q, sat_q;
  logic [RW-1:0] rem0;

  assign rem0 = RW'(num_i) << FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else if (en_i) begin
      val_q <= {val_q[NS-2:0], ctl_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem0;
      den_q[0] <= RW'(den_i);
      quo_q[0] <= '0;
      hit_q[0] <= ctl_i.hit;
      sat_q[0] <= rem0 >= (RW'(den_i) << DistWidth);
      for (int k = 1; k < NS; k++) begin
        den_q[k] <= den_q[k-1];
        hit_q[k] <= hit_q[k-1];
        sat_q[k] <= sat_q[k-1];
        if (rem_q[k-1] >= (den_q[k-1] << (NS-1-k))) begin
          rem_q[k] <= rem_q[k-1] - (den_q[k-1] << (NS-1-k));
          quo_q[k] <= quo_q[k-1] | (DistWidth'(1) << (NS-1-k));
        end else begin
          rem_q[k] <= rem_q[k-1];
          quo_q[k] <= quo_q[k-1];
        end
      end
    end
  end

  assign valid_o = val_q[NS-1];
  always_comb begin
    res_o.hit = hit_q[NS-1];
    if (!hit_q[NS-1]) begin
      res_o.distance = '0;
    end else if (sat_q[NS-1]) begin
      res_o.distance = '1;
    end else begin
      res_o.distance = quo_q[NS-1];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/ray_triangle_intersect.sv =====
// Top level of the ray/triangle intersection tester: ray registers and pipeline.
// Depends on rti_pkg, rti_cross, rti_dot and rti_div.
//
//  channel | signals                               | beat
//  --------+---------------------------------------+-----------------------------
//  in      | in_valid_i, in_stall_o, in_data_i     | one triangle (three vertices)
//  out     | out_valid_o, out_stall_i, out_data_o  | hit flag and distance t
//  cfg     | cfg_valid_i, cfg_ready_o, index, data | one ray register write
//
// One triangle enters per cycle while not stalled; a result passes through three
// cross stages, three dot/test stages, 32 divider stages and one output register.
// The divider stages set the latency; throughput is one beat per unstalled cycle.
// Reset clears the valid bits and loads origin (0,0,0), direction (1,0,0).
// A stalled output beat freezes the whole pipeline; nothing is dropped.
`default_nettype none
module ray_triangle_intersect import rti_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  rti_tri_t               in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output rti_res_t               out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [CoordWidth-1:0]  cfg_data_i
);
  localparam int unsigned NW = 3 * CoordWidth + 5;

  logic signed [CoordWidth-1:0] org_q [3], dir_q [3];
  logic en;
  logic x_valid, d_valid;
  logic signed [2*CoordWidth+2:0] p [3], q [3];
  logic signed [CoordWidth:0] e1 [3], e2 [3], tv [3];
  rti_ctl_t ctl;
  logic [NW-1:0] num, den;
  rti_res_t res;
  logic out_valid_q;
  rti_res_t out_data_q;

  // advance everything unless a finished beat is held at the output
  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q <= '{default: '0};
      dir_q <= '{CoordWidth'(1) << FRAC_BITS, '0, '0};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ORG_X: org_q[0] <= cfg_data_i;
        REG_ORG_Y: org_q[1] <= cfg_data_i;
        REG_ORG_Z: org_q[2] <= cfg_data_i;
        REG_DIR_X: dir_q[0] <= cfg_data_i;
        REG_DIR_Y: dir_q[1] <= cfg_data_i;
        REG_DIR_Z: dir_q[2] <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  rti_cross u_cross (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .tri_i(in_data_i),
    .org_i(org_q), .dir_i(dir_q), .valid_o(x_valid),
    .p_o(p), .q_o(q), .e1_o(e1), .e2_o(e2), .tv_o(tv)
  );

  rti_dot u_dot (
    .clk_i, .rst_ni, .en_i(en), .valid_i(x_valid),
    .p_i(p), .q_i(q), .e1_i(e1), .e2_i(e2), .tv_i(tv), .dir_i(dir_q),
    .ctl_o(ctl), .num_o(num), .den_o(den)
  );

  rti_div #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_div (
    .clk_i, .rst_ni, .en_i(en), .ctl_i(ctl), .num_i(num), .den_i(den),
    .valid_o(d_valid), .res_o(res)
  );

  // output register: hold the beat while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
endmodule
`default_nettype wire

// ===== rtl/core/rti_checker.sv =====
// Port-level checks for ray_triangle_intersect, bound to the top level.
// Depends on rti_pkg.
`default_nettype none
module rti_checker import rti_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input rti_res_t out_data_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat dropped or changed while stalled");

  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.distance == '0)
    else $error("miss with nonzero distance");

  a_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stalled without a held output beat");
endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);
`default_nettype wire
